[sv/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg - shared types and constants of the HSV to RGB converter
// Field widths, fixed-point constants, the command code and the hue sector
// code used between the pipeline modules.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Port field widths
  localparam int HUE_W    = 16;
  localparam int UNIT_W   = 13;
  localparam int POS_W    = 13;
  localparam int MAXHUE_W = 15;
  localparam int CHAN_W   = 8;

  // 3/pi in Q.16, and the width of the sector fraction
  localparam int               SECTOR_BITS = 16;
  localparam logic [15:0]      SECTOR_K    = 16'd62582;
  localparam int               SECPROD_W   = (HUE_W - 1) + 16;

  // Largest hue reachable in range mode
  localparam logic [MAXHUE_W-1:0] HUE_MAX     = 15'h7FFF;
  localparam logic [MAXHUE_W-1:0] MAX_HUE_RST = 15'd25736;

  // Number of hue sectors around the circle
  localparam int NUM_SECTORS = 6;

  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_RANGE   = 1'b1
  } cmd_t;

  // Sector order of (c, x, 0) across red, green and blue
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

[sv/hsv2rgb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_front - operand select, chroma and sector stages
// Stage 1 picks hue, saturation and brightness for the command (range mode
// scales position by max_hue). Stage 2 forms chroma, offset and the sector.
// ----------------------------------------------------------------------------
module hsv2rgb_front import hsv2rgb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [MAXHUE_W-1:0]   max_hue,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [HUE_W-1:0]      in_hue,
  input  logic [UNIT_W-1:0]     in_saturation,
  input  logic [UNIT_W-1:0]     in_brightness,
  input  logic [POS_W-1:0]      in_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2*FRAC_BITS:0]  out_c,
  output logic [2*FRAC_BITS:0]  out_m,
  output logic [SECTOR_BITS-1:0] out_frac,
  output sector_t               out_sec,
  output logic                  out_sec_ok
);

  localparam int UW   = FRAC_BITS + 1;
  localparam int MW   = 2 * FRAC_BITS + 1;
  localparam int CFW  = 2 * UW;
  localparam int CMPW = (UW > UNIT_W) ? UW : UNIT_W;
  localparam int RPW  = POS_W + MAXHUE_W;
  localparam logic [CMPW-1:0] ONE_C = CMPW'(1) << FRAC_BITS;

  // Stage 1 registers
  logic                s1_v_r;
  logic [HUE_W-1:0]    s1_hue_r;
  logic [UW-1:0]       s1_sat_r;
  logic [UW-1:0]       s1_val_r;
  logic                s1_ready;

  // Stage 2 registers
  logic                s2_v_r;
  logic [MW-1:0]       s2_c_r;
  logic [MW-1:0]       s2_m_r;
  logic [SECTOR_BITS-1:0] s2_frac_r;
  sector_t             s2_sec_r;
  logic                s2_ok_r;
  logic                s2_ready;

  // Stage 1 combinational
  logic [RPW-1:0]      range_prod;
  logic [RPW-1:0]      range_hue;
  logic [MAXHUE_W-1:0] range_sat;
  logic [UW-1:0]       sat_clamp;
  logic [UW-1:0]       val_clamp;
  logic [HUE_W-1:0]    s1_hue_nxt;
  logic [UW-1:0]       s1_sat_nxt;
  logic [UW-1:0]       s1_val_nxt;

  // Stage 2 combinational
  logic [CFW-1:0]      chroma_full;
  logic [MW-1:0]       c_nxt;
  logic [MW-1:0]       m_nxt;
  logic [SECPROD_W-1:0] sec_prod;
  logic [SECPROD_W-1:0] sec_pos;
  logic [SECPROD_W-1:0] sec_idx;

  // Ready chain: a stage takes data when empty or when it drains
  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Select operands; range mode saturates the scaled hue
  always_comb begin
    range_prod = RPW'(in_position) * RPW'(max_hue);
    range_hue  = range_prod >> FRAC_BITS;
    range_sat  = (range_hue > RPW'(HUE_MAX)) ? HUE_MAX : range_hue[MAXHUE_W-1:0];
    sat_clamp  = (CMPW'(in_saturation) > ONE_C) ? ONE_C[UW-1:0]
                                                : UW'(in_saturation);
    val_clamp  = (CMPW'(in_brightness) > ONE_C) ? ONE_C[UW-1:0]
                                                : UW'(in_brightness);
    if (cmd_t'(in_cmd) == CMD_RANGE) begin
      s1_hue_nxt = {1'b0, range_sat};
      s1_sat_nxt = ONE_C[UW-1:0];
      s1_val_nxt = ONE_C[UW-1:0];
    end else begin
      s1_hue_nxt = in_hue;
      s1_sat_nxt = sat_clamp;
      s1_val_nxt = val_clamp;
    end
  end

  // Chroma, offset and sector position
  always_comb begin
    chroma_full = CFW'(s1_val_r) * CFW'(s1_sat_r);
    c_nxt       = chroma_full[MW-1:0];
    m_nxt       = (MW'(s1_val_r) << FRAC_BITS) - c_nxt;
    sec_prod    = SECPROD_W'(s1_hue_r[HUE_W-2:0]) * SECPROD_W'(SECTOR_K);
    sec_pos     = sec_prod >> FRAC_BITS;
    sec_idx     = sec_pos >> SECTOR_BITS;
  end

  // Hold valid bits per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  // Advance payload on each transfer
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_hue_r <= s1_hue_nxt;
      s1_sat_r <= s1_sat_nxt;
      s1_val_r <= s1_val_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_c_r    <= c_nxt;
      s2_m_r    <= m_nxt;
      s2_frac_r <= sec_pos[SECTOR_BITS-1:0];
      s2_sec_r  <= sector_t'(sec_idx[2:0]);
      s2_ok_r   <= !s1_hue_r[HUE_W-1] && (sec_idx < SECPROD_W'(NUM_SECTORS));
    end
  end

  assign out_valid  = s2_v_r;
  assign out_c      = s2_c_r;
  assign out_m      = s2_m_r;
  assign out_frac   = s2_frac_r;
  assign out_sec    = s2_sec_r;
  assign out_sec_ok = s2_ok_r;

endmodule

[sv/hsv2rgb_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_mix - secondary component stage
// Weights the chroma by the position inside the sector: the fraction in an
// even sector and its complement in an odd sector.
// ----------------------------------------------------------------------------
module hsv2rgb_mix import hsv2rgb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2*FRAC_BITS:0]   in_c,
  input  logic [2*FRAC_BITS:0]   in_m,
  input  logic [SECTOR_BITS-1:0] in_frac,
  input  sector_t                in_sec,
  input  logic                   in_sec_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2*FRAC_BITS:0]   out_c,
  output logic [2*FRAC_BITS:0]   out_x,
  output logic [2*FRAC_BITS:0]   out_m,
  output sector_t                out_sec,
  output logic                   out_sec_ok
);

  localparam int MW = 2 * FRAC_BITS + 1;
  localparam int WW = SECTOR_BITS + 1;
  localparam int PW = MW + WW;

  logic          v_r;
  logic [MW-1:0] c_r;
  logic [MW-1:0] x_r;
  logic [MW-1:0] m_r;
  sector_t       sec_r;
  logic          ok_r;
  logic          stage_ready;

  logic [WW-1:0] weight;
  logic [PW-1:0] x_prod;

  assign stage_ready = !v_r || out_ready;
  assign in_ready    = stage_ready;

  // Weight the chroma; an odd sector runs the fraction downward
  always_comb begin
    weight = in_sec[0] ? ((WW'(1) << SECTOR_BITS) - WW'(in_frac)) : WW'(in_frac);
    x_prod = PW'(in_c) * PW'(weight);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (stage_ready) begin
      v_r <= in_valid;
    end
  end

  // Advance payload on transfer
  always_ff @(posedge clk) begin
    if (stage_ready && in_valid) begin
      c_r   <= in_c;
      x_r   <= x_prod[MW+SECTOR_BITS-1:SECTOR_BITS];
      m_r   <= in_m;
      sec_r <= in_sec;
      ok_r  <= in_sec_ok;
    end
  end

  assign out_valid  = v_r;
  assign out_c      = c_r;
  assign out_x      = x_r;
  assign out_m      = m_r;
  assign out_sec    = sec_r;
  assign out_sec_ok = ok_r;

endmodule

[sv/hsv2rgb_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_out - channel ordering and scaling stages
// Stage 4 places (c, x, 0) in the sector's channel order and adds the offset.
// Stage 5 scales each channel by 255, truncates and holds the result.
// ----------------------------------------------------------------------------
module hsv2rgb_out import hsv2rgb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2*FRAC_BITS:0] in_c,
  input  logic [2*FRAC_BITS:0] in_x,
  input  logic [2*FRAC_BITS:0] in_m,
  input  sector_t              in_sec,
  input  logic                 in_sec_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue
);

  localparam int MW = 2 * FRAC_BITS + 1;
  localparam int SW = MW + CHAN_W;

  // Stage 4 registers
  logic          s4_v_r;
  logic [MW-1:0] s4_red_r;
  logic [MW-1:0] s4_grn_r;
  logic [MW-1:0] s4_blu_r;
  logic          s4_ready;

  // Stage 5 (output) registers
  logic              s5_v_r;
  logic [CHAN_W-1:0] s5_red_r;
  logic [CHAN_W-1:0] s5_grn_r;
  logic [CHAN_W-1:0] s5_blu_r;
  logic              s5_ready;

  logic [MW-1:0] prim_r;
  logic [MW-1:0] prim_g;
  logic [MW-1:0] prim_b;

  // Scale a unit value in Q.(2*FRAC_BITS) by 255 and truncate
  function automatic logic [CHAN_W-1:0] scale_chan(input logic [MW-1:0] val);
    logic [SW-1:0] scaled;
    scaled = (SW'(val) << CHAN_W) - SW'(val);
    return scaled[2*FRAC_BITS+CHAN_W-1:2*FRAC_BITS];
  endfunction

  assign s5_ready = !s5_v_r || out_ready;
  assign s4_ready = !s4_v_r || s5_ready;
  assign in_ready = s4_ready;

  // Decode sector into channel order; out-of-range hue gives no primaries
  always_comb begin
    prim_r = '0;
    prim_g = '0;
    prim_b = '0;
    if (in_sec_ok) begin
      unique case (in_sec)
        SEC_RED_YEL: begin prim_r = in_c; prim_g = in_x; end
        SEC_YEL_GRN: begin prim_r = in_x; prim_g = in_c; end
        SEC_GRN_CYN: begin prim_g = in_c; prim_b = in_x; end
        SEC_CYN_BLU: begin prim_g = in_x; prim_b = in_c; end
        SEC_BLU_MAG: begin prim_r = in_x; prim_b = in_c; end
        SEC_MAG_RED: begin prim_r = in_c; prim_b = in_x; end
        default: begin
          prim_r = '0;
          prim_g = '0;
          prim_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (s4_ready) s4_v_r <= in_valid;
      if (s5_ready) s5_v_r <= s4_v_r;
    end
  end

  // Advance payload on each transfer
  always_ff @(posedge clk) begin
    if (s4_ready && in_valid) begin
      s4_red_r <= prim_r + in_m;
      s4_grn_r <= prim_g + in_m;
      s4_blu_r <= prim_b + in_m;
    end
    if (s5_ready && s4_v_r) begin
      s5_red_r <= scale_chan(s4_red_r);
      s5_grn_r <= scale_chan(s4_grn_r);
      s5_blu_r <= scale_chan(s4_blu_r);
    end
  end

  assign out_valid = s5_v_r;
  assign out_red   = s5_red_r;
  assign out_green = s5_grn_r;
  assign out_blue  = s5_blu_r;

endmodule

[sv/hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter - fixed-point HSV to 8-bit RGB converter
// Converts one hue/saturation/brightness item, or one range position, to an
// RGB pixel through a five-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the output stalls it, and returns
// each pixel in order. Every stage has its own valid bit and ready term, so
// a stalled output only holds the stages behind it that are full; the input
// keeps taking items while bubbles remain. The five stages are operand select
// (with the position times max_hue product), chroma and sector multiplies,
// the secondary-weight multiply, channel ordering with offset add, and the
// scale by 255 into the output register. max_hue is written through cfg_we /
// cfg_wdata and should only change while the pipeline is empty.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [MAXHUE_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [HUE_W-1:0]    in_hue,
  input  logic [UNIT_W-1:0]   in_saturation,
  input  logic [UNIT_W-1:0]   in_brightness,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAN_W-1:0]   out_red,
  output logic [CHAN_W-1:0]   out_green,
  output logic [CHAN_W-1:0]   out_blue
);

  localparam int MW = 2 * FRAC_BITS + 1;

  logic [MAXHUE_W-1:0] max_hue_r;

  logic                   fr_valid;
  logic                   fr_ready;
  logic [MW-1:0]          fr_c;
  logic [MW-1:0]          fr_m;
  logic [SECTOR_BITS-1:0] fr_frac;
  sector_t                fr_sec;
  logic                   fr_sec_ok;

  logic                   mx_valid;
  logic                   mx_ready;
  logic [MW-1:0]          mx_c;
  logic [MW-1:0]          mx_x;
  logic [MW-1:0]          mx_m;
  sector_t                mx_sec;
  logic                   mx_sec_ok;

  // Hold the range-mode hue span
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_hue_r <= MAX_HUE_RST;
    end else if (cfg_we) begin
      max_hue_r <= cfg_wdata;
    end
  end

  hsv2rgb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .max_hue      (max_hue_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .in_position  (in_position),
    .out_valid    (fr_valid),
    .out_ready    (fr_ready),
    .out_c        (fr_c),
    .out_m        (fr_m),
    .out_frac     (fr_frac),
    .out_sec      (fr_sec),
    .out_sec_ok   (fr_sec_ok)
  );

  hsv2rgb_mix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_c      (fr_c),
    .in_m      (fr_m),
    .in_frac   (fr_frac),
    .in_sec    (fr_sec),
    .in_sec_ok (fr_sec_ok),
    .out_valid (mx_valid),
    .out_ready (mx_ready),
    .out_c     (mx_c),
    .out_x     (mx_x),
    .out_m     (mx_m),
    .out_sec   (mx_sec),
    .out_sec_ok(mx_sec_ok)
  );

  hsv2rgb_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mx_valid),
    .in_ready (mx_ready),
    .in_c     (mx_c),
    .in_x     (mx_x),
    .in_m     (mx_m),
    .in_sec   (mx_sec),
    .in_sec_ok(mx_sec_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue)
  );

endmodule

[test/tb_hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter - self-checking bench for the HSV to RGB converter
// Walks a table of directed pixels, then random pixels over several max_hue
// settings. The table's typed color, or else a bit-exact color model, gives each
// pixel at input transfer, and output transfers are compared in order, channel by channel.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
  import hsv2rgb_pkg::*;

  localparam int FRAC_BITS    = 12;
  localparam int UNIT_ONE     = 1 << FRAC_BITS;
  localparam int CHAN_SCALE   = 255;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_PIXELS = 200;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct {
    cmd_t              cmd;
    logic [HUE_W-1:0]  hue;
    logic [UNIT_W-1:0] sat;
    logic [UNIT_W-1:0] bri;
    logic [POS_W-1:0]  pos;
    logic              known;
    pixel_t            want;
  } stim_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [MAXHUE_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_cmd;
  logic [HUE_W-1:0]    in_hue;
  logic [UNIT_W-1:0]   in_saturation;
  logic [UNIT_W-1:0]   in_brightness;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic                out_ready;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;

  // Bench-side copy of the hue span register
  logic [MAXHUE_W-1:0] hue_span_cfg;

  // Known result of the item on the input port, if typed in the table
  logic   cur_known;
  pixel_t cur_want;

  pixel_t pixels_due_q[$];
  int     pixels_due;
  int     error_count;
  bit     gaps_on;
  bit     hold_req;
  int     hold_left;
  stim_t  directed_q[$];

  hsv_to_rgb_converter #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Color model: fixed-point HSV (or range position) to 8-bit RGB
  function automatic pixel_t predict_pixel(cmd_t cmd, logic [HUE_W-1:0] hue,
                                           logic [UNIT_W-1:0] sat,
                                           logic [UNIT_W-1:0] bri,
                                           logic [POS_W-1:0] pos,
                                           logic [MAXHUE_W-1:0] hue_span);
    logic [63:0] angle;
    logic [63:0] sat_u;
    logic [63:0] bri_u;
    logic [63:0] sector;
    logic [63:0] weight;
    logic [63:0] chroma;
    logic [63:0] secondary;
    logic [63:0] offset;
    logic [63:0] scaled;
    logic [63:0] prim [3];
    logic [CHAN_W-1:0] chan [3];
    logic        neg;
    pixel_t      px;
    if (cmd == CMD_RANGE) begin
      // Scale position by the span, saturate to the top of the hue range
      angle = 64'(pos);
      angle = (angle * 64'(hue_span)) >> FRAC_BITS;
      if (angle > 64'(HUE_MAX))
        angle = 64'(HUE_MAX);
      neg   = 1'b0;
      sat_u = 64'(UNIT_ONE);
      bri_u = 64'(UNIT_ONE);
    end else begin
      neg   = hue[HUE_W-1];
      angle = 64'(hue[HUE_W-2:0]);
      sat_u = (64'(sat) > 64'(UNIT_ONE)) ? 64'(UNIT_ONE) : 64'(sat);
      bri_u = (64'(bri) > 64'(UNIT_ONE)) ? 64'(UNIT_ONE) : 64'(bri);
    end
    chroma = bri_u * sat_u;
    offset = bri_u * 64'(UNIT_ONE) - chroma;
    for (int k = 0; k < 3; k++)
      prim[k] = 64'd0;
    // Negative hue or sector six and up leaves every primary at zero
    if (!neg) begin
      sector    = (angle * 64'(SECTOR_K)) >> FRAC_BITS;
      weight    = 64'(sector[15:0]);
      if (sector[16])
        weight = (64'd1 << SECTOR_BITS) - weight;
      secondary = (chroma * weight) >> SECTOR_BITS;
      case (sector_t'(sector[18:16]))
        SEC_RED_YEL: begin prim[0] = chroma;    prim[1] = secondary; end
        SEC_YEL_GRN: begin prim[0] = secondary; prim[1] = chroma;    end
        SEC_GRN_CYN: begin prim[1] = chroma;    prim[2] = secondary; end
        SEC_CYN_BLU: begin prim[1] = secondary; prim[2] = chroma;    end
        SEC_BLU_MAG: begin prim[0] = secondary; prim[2] = chroma;    end
        SEC_MAG_RED: begin prim[0] = chroma;    prim[2] = secondary; end
        default: ;
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      scaled  = ((prim[k] + offset) * 64'(CHAN_SCALE)) >> (2 * FRAC_BITS);
      chan[k] = scaled[CHAN_W-1:0];
    end
    px.red   = chan[0];
    px.green = chan[1];
    px.blue  = chan[2];
    return px;
  endfunction

  task automatic check_channel(string chan, logic [CHAN_W-1:0] want,
                               logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
      error_count++;
    end
  endtask

  // Scoreboard: record the expected pixel at input transfer, check at output
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (cur_known)
          pixels_due_q.push_back(cur_want);
        else
          pixels_due_q.push_back(predict_pixel(cmd_t'(in_cmd), in_hue, in_saturation,
                                               in_brightness, in_position, hue_span_cfg));
        pixels_due++;
      end
      if (out_valid && out_ready) begin
        if (pixels_due_q.size() == 0) begin
          $display("%0t ns: unexpected pixel, actual %0d %0d %0d", $time,
                   out_red, out_green, out_blue);
          error_count++;
        end else begin
          want = pixels_due_q.pop_front();
          pixels_due--;
          check_channel("red", want.red, out_red);
          check_channel("green", want.green, out_green);
          check_channel("blue", want.blue, out_blue);
        end
      end
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = !(gaps_on && $urandom_range(0, 99) < 12);
      end
    end
  end

  // Offer one item and hold it until its transfer
  task automatic offer_pixel(input stim_t st);
    if (gaps_on && $urandom_range(0, 99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_cmd        = st.cmd;
    in_hue        = st.hue;
    in_saturation = st.sat;
    in_brightness = st.bri;
    in_position   = st.pos;
    cur_known     = st.known;
    cur_want      = st.want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait for every pending pixel, then settle
  task automatic drain_pipeline(int settle);
    in_valid = 1'b0;
    while (pixels_due != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_hue_span(logic [MAXHUE_W-1:0] span);
    drain_pipeline(SETTLE_CYCLES);
    cfg_wdata = span;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we       = 1'b0;
    hue_span_cfg = span;
  endtask

  task automatic add_case(cmd_t cmd, int hue, int sat, int bri, int pos,
                          bit known, int r, int g, int b);
    stim_t st;
    st.cmd        = cmd;
    st.hue        = HUE_W'(hue);
    st.sat        = UNIT_W'(sat);
    st.bri        = UNIT_W'(bri);
    st.pos        = POS_W'(pos);
    st.known      = known;
    st.want.red   = CHAN_W'(r);
    st.want.green = CHAN_W'(g);
    st.want.blue  = CHAN_W'(b);
    directed_q.push_back(st);
  endtask

  // Mostly in-range values, with the out-of-range corners mixed in
  function automatic stim_t random_pixel();
    stim_t st;
    int    pick;
    st.cmd = cmd_t'($urandom_range(0, 1));
    pick   = $urandom_range(0, 9);
    if (pick < 6)
      st.hue = HUE_W'($urandom_range(0, 25735));
    else if (pick == 7)
      st.hue = HUE_W'($urandom_range(25736, 32767));
    else if (pick == 8)
      st.hue = HUE_W'($urandom_range(0, 65535) | 32'h8000);
    else
      st.hue = HUE_W'($urandom_range(0, 65535));
    st.sat   = ($urandom_range(0, 4) == 0) ? UNIT_W'($urandom_range(0, 8191))
                                           : UNIT_W'($urandom_range(0, UNIT_ONE));
    st.bri   = ($urandom_range(0, 4) == 0) ? UNIT_W'($urandom_range(0, 8191))
                                           : UNIT_W'($urandom_range(0, UNIT_ONE));
    st.pos   = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 8191))
                                           : POS_W'($urandom_range(0, UNIT_ONE));
    st.known = 1'b0;
    st.want  = '0;
    return st;
  endfunction

  // Stimulus
  initial begin
    logic [MAXHUE_W-1:0] spans [NUM_PHASES];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_cmd        = CMD_CONVERT;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    in_position   = '0;
    cur_known     = 1'b0;
    cur_want      = '0;
    pixels_due    = 0;
    error_count   = 0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    hue_span_cfg  = MAX_HUE_RST;

    // Directed table: known colors where obvious, model otherwise
    add_case(CMD_CONVERT, 0, 0, 0, 0, 1, 0, 0, 0);
    add_case(CMD_CONVERT, 0, 4096, 4096, 0, 1, 255, 0, 0);
    add_case(CMD_CONVERT, 0, 0, 4096, 0, 1, 255, 255, 255);
    add_case(CMD_CONVERT, -32768, 4096, 4096, 0, 1, 0, 0, 0);
    add_case(CMD_CONVERT, -1, 0, 4096, 0, 1, 255, 255, 255);
    add_case(CMD_CONVERT, 32767, 4096, 4096, 0, 1, 0, 0, 0);
    add_case(CMD_CONVERT, 25800, 4096, 2048, 0, 1, 0, 0, 0);
    add_case(CMD_CONVERT, 0, 8191, 8191, 0, 1, 255, 0, 0);
    add_case(CMD_CONVERT, 0, 4097, 4096, 0, 1, 255, 0, 0);
    add_case(CMD_CONVERT, 8192, 4096, 0, 0, 1, 0, 0, 0);
    add_case(CMD_RANGE, 0, 0, 0, 0, 1, 255, 0, 0);
    add_case(CMD_RANGE, 0, 0, 0, 8191, 1, 0, 0, 0);
    add_case(CMD_RANGE, 0, 0, 0, 4096, 0, 0, 0, 0);
    add_case(CMD_RANGE, -1, 8191, 0, 2048, 0, 0, 0, 0);
    add_case(CMD_RANGE, 12345, 1000, 3000, 4095, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 2144, 4096, 4096, 0, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 4289, 4096, 4096, 0, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 6433, 3000, 4000, 0, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 10722, 4096, 4096, 0, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 15011, 2048, 4096, 0, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 19300, 4096, 3500, 0, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 23589, 4096, 4096, 0, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 25735, 4096, 4096, 8191, 0, 0, 0, 0);
    add_case(CMD_CONVERT, 12345, 1234, 3000, 8191, 0, 0, 0, 0);

    // Settings per random phase, both extremes included
    spans[0] = '0;
    spans[1] = HUE_MAX;
    spans[2] = MAXHUE_W'($urandom_range(1, 32766));
    spans[3] = MAX_HUE_RST;
    spans[4] = 15'd4096;
    spans[5] = MAXHUE_W'($urandom_range(1, 32766));

    // Hold reset before releasing it
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_q[i])
      offer_pixel(directed_q[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_hue_span(spans[p]);
      // One phase runs with no idling on either side
      gaps_on = (p != 2);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (p == 3 && n == 50)
          hold_req = 1'b1;
        if (p == 4 && n == 100)
          drain_pipeline(0);
        offer_pixel(random_pixel());
      end
    end

    drain_pipeline(SETTLE_CYCLES);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
